[src/mba_pkg.sv]
// shared widths, limits and register codes for the block averager
package mba_pkg;

  localparam int CH_BITS    = 3;
  localparam int SMP_BITS   = 12;
  localparam int AVG_BITS   = 12;
  localparam int SUM_BITS   = 28;
  localparam int COUNT_BITS = 17;
  localparam int WLOG_BITS  = 5;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [WLOG_BITS-1:0] WLOG_MAX   = 5'd16;
  localparam logic [WLOG_BITS-1:0] WLOG_RESET = 5'd11;

  // register index taken from paddr above the byte offset
  localparam logic [CFG_ADDR_BITS-3:0] REG_WINDOW_LOG2 = 1'b0;

endpackage

[src/mba_if.sv]
// sample and result stream interfaces
interface mba_in_if import mba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_BITS-1:0]  channel;
  logic [SMP_BITS-1:0] sample_value;

  modport source (output valid, output channel, output sample_value, input ready);
  modport sink   (input valid, input channel, input sample_value, output ready);
endinterface

interface mba_out_if import mba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_BITS-1:0]  out_channel;
  logic [AVG_BITS-1:0] average;
  logic                last;

  modport source (output valid, output out_channel, output average, output last, input ready);
  modport sink   (input valid, input out_channel, input average, input last, output ready);
endinterface

[src/multichannel_block_averager.sv]
// multichannel power-of-two block averager with accumulator memory
// a word and its accumulator read are registered at acceptance, and a closing word's average
// is then registered for output; a new word is taken only after the last one is written back
//   (memory read, add, write back), and later while a full output register holds a result
// words for channels beyond CHANNELS are taken and dropped
// reset (rst_n low, synchronous): accumulators read as zero, scan count zero, window_log2 = 11
module multichannel_block_averager import mba_pkg::*; #(
  parameter int CHANNELS    = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mba_in_if.sink                   in_strm,
  mba_out_if.source                out_strm,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SMP_KEEP = (SAMPLE_BITS < SMP_BITS) ? SAMPLE_BITS : SMP_BITS;
  localparam logic [SMP_BITS-1:0] SMP_MASK = SMP_BITS'((33'd1 << SMP_KEEP) - 33'd1);
  localparam logic [CH_BITS:0]    CH_COUNT = (CH_BITS+1)'(CHANNELS);
  localparam logic [CH_BITS-1:0]  CH_LAST  = CH_BITS'(CHANNELS - 1);

  // configuration
  logic [WLOG_BITS-1:0] window_log2_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_log2_r <= WLOG_RESET;
    end else if (cfg_wr && paddr[CFG_ADDR_BITS-1:2] == REG_WINDOW_LOG2) begin
      window_log2_r <= pwdata[WLOG_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_BITS-1:2] == REG_WINDOW_LOG2) begin
      prdata = CFG_DATA_BITS'(window_log2_r);
    end
  end

  // accept stage
  logic                in_acc;
  logic                in_hit;
  logic                busy_r;
  logic [CH_BITS-1:0]  ch_r;
  logic [SMP_BITS-1:0] smp_r;

  assign in_strm.ready = !busy_r;
  assign in_acc        = in_strm.valid && !busy_r;
  assign in_hit        = {1'b0, in_strm.channel} < CH_COUNT;

  // accumulator memory, one entry per channel
  logic [SUM_BITS-1:0] sums_mem [CHANNELS];
  logic [SUM_BITS-1:0] sum_rd_r;
  logic [CHANNELS-1:0] vld_r;
  logic                wr_en;
  logic [SUM_BITS-1:0] wr_data;
  logic [IDX_BITS-1:0] wr_idx;

  assign wr_idx = ch_r[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && in_hit) begin
      sum_rd_r <= sums_mem[in_strm.channel[IDX_BITS-1:0]];
    end
    if (wr_en) begin
      sums_mem[wr_idx] <= wr_data;
    end
  end

  // update stage
  logic [COUNT_BITS-1:0] scan_count_r;
  logic [COUNT_BITS-1:0] scan_count_nxt;
  logic [WLOG_BITS-1:0]  wl;
  logic [COUNT_BITS-1:0] tm1;
  logic [SUM_BITS-1:0]   sum_old;
  logic [SUM_BITS-1:0]   sum_new;
  logic [SUM_BITS-1:0]   sum_shift;
  logic                  final_scan;
  logic                  last_ch;
  logic                  done;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [CH_BITS-1:0]    out_channel_r;
  logic [AVG_BITS-1:0]   average_r;
  logic                  last_r;

  always_comb begin
    wl         = (window_log2_r > WLOG_MAX) ? WLOG_MAX : window_log2_r;
    tm1        = (COUNT_BITS'(1) << wl) - COUNT_BITS'(1);
    sum_old    = vld_r[wr_idx] ? sum_rd_r : '0;
    sum_new    = sum_old + SUM_BITS'(smp_r);
    sum_shift  = sum_new >> wl;
    final_scan = scan_count_r >= tm1;
    last_ch    = ch_r == CH_LAST;
    // a closing word must find the output register free or draining
    done       = busy_r && (!final_scan || !out_valid_r || out_strm.ready);
    wr_en      = done;
    wr_data    = final_scan ? '0 : sum_new;

    scan_count_nxt = scan_count_r;
    if (done && last_ch) begin
      scan_count_nxt = final_scan ? '0 : scan_count_r + COUNT_BITS'(1);
    end

    out_valid_nxt = out_valid_r && !out_strm.ready;
    if (done && final_scan) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      vld_r        <= '0;
      scan_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc && in_hit) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      scan_count_r <= scan_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_strm.channel;
      smp_r <= in_strm.sample_value & SMP_MASK;
    end
    if (done && final_scan) begin
      out_channel_r <= ch_r;
      average_r     <= sum_shift[AVG_BITS-1:0];
      last_r        <= last_ch;
    end
  end

  assign out_strm.valid       = out_valid_r;
  assign out_strm.out_channel = out_channel_r;
  assign out_strm.average     = average_r;
  assign out_strm.last        = last_r;

endmodule

[src/mba_checker.sv]
// port-level checks for the block averager, bound to the top level
module mba_checker import mba_pkg::*; #(
  parameter int CHANNELS = 5
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [CH_BITS-1:0] in_channel,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CH_BITS-1:0] out_channel,
  input logic               out_last
);

  localparam logic [CH_BITS:0]   CH_COUNT = (CH_BITS+1)'(CHANNELS);
  localparam logic [CH_BITS-1:0] CH_LAST  = CH_BITS'(CHANNELS - 1);

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_channel == CH_LAST)
    else $error("last flag on a channel other than the final one");

  a_not_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_channel != CH_LAST)
    else $error("final channel result without last flag");

  // an in-range word keeps the update stage busy for the next cycle
  a_busy_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ({1'b0, in_channel} < CH_COUNT) |=> !in_ready)
    else $error("word accepted while previous word still updating");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind multichannel_block_averager mba_checker #(.CHANNELS(CHANNELS)) u_mba_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_strm.valid),
  .in_ready    (in_strm.ready),
  .in_channel  (in_strm.channel),
  .out_valid   (out_strm.valid),
  .out_ready   (out_strm.ready),
  .out_channel (out_strm.out_channel),
  .out_last    (out_strm.last)
);

[tb/sv/multichannel_block_averager_tb.sv]
// self-checking testbench for the multichannel block averager: directed table, then random scans
module multichannel_block_averager_tb import mba_pkg::*; ();

  localparam int NUM_CH = 5;
  localparam logic [CFG_ADDR_BITS-1:0] WINDOW_ADDR = {REG_WINDOW_LOG2, 2'b00};
  localparam int RANDOM_WORDS = 620;

  typedef struct packed {
    logic [CH_BITS-1:0]  ch;
    logic [AVG_BITS-1:0] avg;
    logic                last;
  } avg_word_t;

  typedef struct packed {
    logic                 set_w;
    logic [WLOG_BITS-1:0] w;
    logic [CH_BITS-1:0]   ch;
    logic [SMP_BITS-1:0]  smp;
    logic                 typed;
    logic [AVG_BITS-1:0]  t_avg;
    logic                 t_last;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  mba_in_if  in_if ();
  mba_out_if out_if ();

  multichannel_block_averager #(
    .CHANNELS    (NUM_CH),
    .SAMPLE_BITS (SMP_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_strm  (in_if),
    .out_strm (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state
  logic [SUM_BITS-1:0]   acc_sums [NUM_CH];
  logic [COUNT_BITS-1:0] scans_done;
  logic [WLOG_BITS-1:0]  window_q;

  avg_word_t expected_avgs [$];
  dir_row_t  directed_rows [0:21];

  int  errors;
  int  items_in;
  int  dropped_in;
  int  averages_checked;
  int  windows_closed;
  int  cfg_writes;
  bit  sender_quiet;
  bit  hold_off_go;
  bit  hold_done;
  int  rcv_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("timeout at %0t, %0d averages still expected", $realtime, expected_avgs.size());
    $display("** multichannel_block_averager: FAILED **");
    $finish;
  end

  function automatic bit predict_average(input logic [CH_BITS-1:0] ch,
                                         input logic [SMP_BITS-1:0] smp,
                                         output avg_word_t res);
    logic [WLOG_BITS-1:0]  w;
    logic [COUNT_BITS-1:0] target_m1;
    logic [SUM_BITS-1:0]   shifted;
    bit                    final_scan;
    bit                    last_ch;
    res = '0;
    if (ch >= NUM_CH) return 1'b0;
    w = (window_q > WLOG_MAX) ? WLOG_MAX : window_q;
    target_m1 = (COUNT_BITS'(1) << w) - COUNT_BITS'(1);
    acc_sums[ch] = acc_sums[ch] + SUM_BITS'(smp);
    final_scan = scans_done >= target_m1;
    last_ch = (ch == CH_BITS'(NUM_CH - 1));
    if (!final_scan) begin
      if (last_ch) scans_done = scans_done + COUNT_BITS'(1);
      return 1'b0;
    end
    shifted = acc_sums[ch] >> w;
    res.ch = ch;
    res.avg = shifted[AVG_BITS-1:0];
    res.last = last_ch;
    acc_sums[ch] = '0;
    if (last_ch) scans_done = '0;
    return 1'b1;
  endfunction

  function automatic logic [SMP_BITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SMP_BITS'($urandom_range(0, (1 << SMP_BITS) - 1));
  endfunction

  task automatic send_word(input logic [CH_BITS-1:0] ch, input logic [SMP_BITS-1:0] smp,
                           input bit typed = 1'b0, input logic [AVG_BITS-1:0] t_avg = '0,
                           input logic t_last = 1'b0);
    avg_word_t res;
    bit        emits;
    if (!sender_quiet && $urandom_range(0, 99) < 11) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.channel      <= ch;
    in_if.sample_value <= smp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    emits = predict_average(ch, smp, res);
    if (typed) begin
      res.ch = ch;
      res.avg = t_avg;
      res.last = t_last;
      emits = 1'b1;
    end
    if (emits) expected_avgs.push_back(res);
    if (ch < NUM_CH) items_in++;
    else dropped_in++;
  endtask

  // drop valid and wait for every expected average, then let the pipeline settle
  task automatic hold_until_drained(input int settle);
    in_if.valid <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_DATA_BITS-1:0] wdata,
                            output logic [CFG_DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WINDOW_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    // idle between transfers
    @(posedge clk);
  endtask

  task automatic set_window(input logic [WLOG_BITS-1:0] w, input bit noisy_upper);
    logic [CFG_DATA_BITS-1:0] wdata;
    logic [CFG_DATA_BITS-1:0] rdata;
    wdata = {{(CFG_DATA_BITS-WLOG_BITS){1'b0}}, w};
    if (noisy_upper) wdata = ($urandom() & ~32'h1F) | wdata;
    hold_until_drained(8);
    apb_access(1'b1, wdata, rdata);
    window_q = w;
    cfg_writes++;
    apb_access(1'b0, '0, rdata);
    if (rdata[WLOG_BITS-1:0] !== w) begin
      errors++;
      $display("%0t window_log2 readback: expected %0d, actual %0d", $realtime, w,
               rdata[WLOG_BITS-1:0]);
    end
  endtask

  // result side: random stalls, a quiet stretch, and one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    rcv_cycles = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        rcv_cycles++;
        if (hold_off_go && !hold_done) begin
          out_if.ready <= 1'b0;
          repeat (300) @(posedge clk);
          hold_done = 1'b1;
        end else begin
          out_if.ready <= (rcv_cycles >= 600 && rcv_cycles < 1400) ||
                          ($urandom_range(0, 99) >= 11);
        end
      end
    end
  end

  always @(posedge clk) begin
    avg_word_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_avgs.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual ch %0d avg %0d last %0b",
                 $realtime, out_if.out_channel, out_if.average, out_if.last);
      end else begin
        exp_w = expected_avgs.pop_front();
        averages_checked++;
        if (exp_w.last) windows_closed++;
        if (out_if.out_channel !== exp_w.ch) begin
          errors++;
          $display("%0t out_channel: expected %0d, actual %0d", $realtime, exp_w.ch,
                   out_if.out_channel);
        end
        if (out_if.average !== exp_w.avg) begin
          errors++;
          $display("%0t average (ch %0d): expected %0d, actual %0d", $realtime, exp_w.ch,
                   exp_w.avg, out_if.average);
        end
        if (out_if.last !== exp_w.last) begin
          errors++;
          $display("%0t last (ch %0d): expected %0b, actual %0b", $realtime, exp_w.ch,
                   exp_w.last, out_if.last);
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] rdata;
    logic [WLOG_BITS-1:0]     w;
    int                       r;
    int                       scans;
    int                       phase;
    int                       rand_goal;
    in_if.valid        <= 1'b0;
    in_if.channel      <= '0;
    in_if.sample_value <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    errors = 0;
    items_in = 0;
    dropped_in = 0;
    averages_checked = 0;
    windows_closed = 0;
    cfg_writes = 0;
    sender_quiet = 1'b0;
    hold_off_go = 1'b0;
    window_q = WLOG_RESET;
    scans_done = '0;
    for (int i = 0; i < NUM_CH; i++) acc_sums[i] = '0;

    // set_w, w, ch, sample, typed, average, last
    directed_rows = '{
      '{1'b0, 5'd0,  3'd0, 12'd4095, 1'b0, 12'd0,    1'b0}, // accumulates, reset window
      '{1'b1, 5'd0,  3'd0, 12'd1,    1'b1, 12'd0,    1'b0}, // 4096 wraps to zero in 12 bits
      '{1'b0, 5'd0,  3'd4, 12'd4095, 1'b1, 12'd4095, 1'b1},
      '{1'b0, 5'd0,  3'd1, 12'd0,    1'b1, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd2, 12'd2730, 1'b1, 12'd2730, 1'b0},
      '{1'b0, 5'd0,  3'd3, 12'd1365, 1'b1, 12'd1365, 1'b0},
      '{1'b0, 5'd0,  3'd5, 12'd123,  1'b0, 12'd0,    1'b0}, // channels past the last: dropped
      '{1'b0, 5'd0,  3'd6, 12'd4095, 1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd7, 12'd0,    1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd2, 12'd2048, 1'b1, 12'd2048, 1'b0},
      '{1'b0, 5'd0,  3'd2, 12'd7,    1'b1, 12'd7,    1'b0}, // repeated channel in final scan
      '{1'b1, 5'd16, 3'd0, 12'd4095, 1'b0, 12'd0,    1'b0}, // widest window
      '{1'b0, 5'd0,  3'd0, 12'd4095, 1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd1, 12'd100,  1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd4, 12'd4095, 1'b0, 12'd0,    1'b0},
      '{1'b1, 5'd31, 3'd0, 12'd4095, 1'b0, 12'd0,    1'b0}, // above max, clamps to 16
      '{1'b1, 5'd1,  3'd0, 12'd1,    1'b0, 12'd0,    1'b0}, // shrink mid-window: closes now
      '{1'b0, 5'd0,  3'd1, 12'd5,    1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd0, 12'd3,    1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd4, 12'd10,   1'b0, 12'd0,    1'b0},
      '{1'b1, 5'd2,  3'd3, 12'd4095, 1'b0, 12'd0,    1'b0},
      '{1'b0, 5'd0,  3'd4, 12'd4095, 1'b0, 12'd0,    1'b0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, '0, rdata);
    if (rdata[WLOG_BITS-1:0] !== WLOG_RESET) begin
      errors++;
      $display("%0t window_log2 after reset: expected %0d, actual %0d", $realtime,
               WLOG_RESET, rdata[WLOG_BITS-1:0]);
    end

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_w) set_window(directed_rows[i].w, 1'b0);
      send_word(directed_rows[i].ch, directed_rows[i].smp, directed_rows[i].typed,
                directed_rows[i].t_avg, directed_rows[i].t_last);
    end

    // random part: whole scans in order with random samples, some noise words
    rand_goal = items_in + RANDOM_WORDS;
    phase = 0;
    while (items_in < rand_goal) begin
      r = $urandom_range(0, 9);
      if (phase == 1) w = '0;
      else if (r < 7) w = WLOG_BITS'($urandom_range(0, 3));
      else if (r == 7) w = 5'd4;
      else w = WLOG_BITS'($urandom_range(5, 31));
      set_window(w, 1'($urandom_range(0, 1)));

      if (phase == 1) scans = 14;
      else if (w <= 4) scans = (1 << w) * $urandom_range(1, 3);
      else scans = $urandom_range(1, 4);

      // output held off while words keep coming, so the block backs up
      if (phase == 1) hold_off_go = 1'b1;

      for (int s = 0; s < scans; s++) begin
        sender_quiet = (phase == 1) ||
                       (items_in - rand_goal + RANDOM_WORDS >= 250 &&
                        items_in - rand_goal + RANDOM_WORDS < 400);
        if (phase == 2 && s == scans / 2) hold_until_drained(1);
        for (int c = 0; c < NUM_CH; c++) begin
          if ($urandom_range(0, 99) < 8)
            send_word(CH_BITS'($urandom_range(0, 7)), rand_sample());
          send_word(CH_BITS'(c), rand_sample());
          if ($urandom_range(0, 99) < 3) send_word(CH_BITS'(c), rand_sample());
        end
      end
      sender_quiet = 1'b0;
      phase++;
    end

    hold_until_drained(10);
    $display("covered %0d samples and %0d dropped words over %0d window settings",
             items_in, dropped_in, cfg_writes);
    $display("checked %0d averages, %0d windows closed", averages_checked, windows_closed);
    if (errors == 0) begin
      $display("** multichannel_block_averager: PASSED **");
    end else begin
      $display("** multichannel_block_averager: FAILED **");
    end
    $finish;
  end

endmodule
